// ===== hw/rtl/prb_pkg.sv =====
// shared constants, codes and result type of the packet ring buffer
`default_nettype none

package prb_pkg;

  // default geometry
  localparam int DEF_SLOTS      = 16;
  localparam int DEF_SLOT_BYTES = 64;

  // queue depths between the parts
  localparam int CMD_FIFO_DEPTH = 2;
  localparam int OUT_FIFO_DEPTH = 4;

  // field widths
  localparam int RING_W     = 5;
  localparam int LEN_W      = 7;
  localparam int BYTE_W     = 8;
  localparam int STAT_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  // reader capacity saturates here
  localparam logic [LEN_W-1:0] CAP_MAX = 7'd64;

  // register reset values
  localparam logic [RING_W-1:0] RST_SLOTS_IN_USE = 5'd16;
  localparam logic [LEN_W-1:0]  RST_PACKET_LIMIT = 7'd64;

  // input beat kinds
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SLOTS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PACKET_LIMIT = 1'b1;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_DATA    = 2'd0,
    STAT_EMPTY   = 2'd1,
    STAT_DISCARD = 2'd2
  } pop_status_t;

  // one result beat
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    pop_status_t       status;
    logic [LEN_W-1:0]  count;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/packet_ring_buffer.sv =====
// top level of the packet ring buffer
//
//  channel   handshake               payload
//  input     push / full             kind, push_byte, push_last, reader_capacity
//  result    pop / empty             pop_byte, pop_last, pop_status, delivered_count
//  config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// the front end takes push bytes and queues pops; the back end looks up the
// length of a queued pop, then streams its bytes while the result queue has
// room and takes no new pop until done (single store read port). a push
// waits while a pop is queued or while its slot is read.
// reset is synchronous and clears pointers and slot flags at once.
// the result queue holds four beats, so a stalled reader stops the back end.
`default_nettype none

module packet_ring_buffer import prb_pkg::*; #(
  parameter int SLOTS      = DEF_SLOTS,
  parameter int SLOT_BYTES = DEF_SLOT_BYTES
) (
  input  logic                  clk,
  input  logic                  rst,
  // input beats
  input  logic                  push,
  output logic                  full,
  input  logic                  kind,
  input  logic [BYTE_W-1:0]     push_byte,
  input  logic                  push_last,
  input  logic [LEN_W-1:0]      reader_capacity,
  // result beats
  output logic                  empty,
  input  logic                  pop,
  output logic [BYTE_W-1:0]     pop_byte,
  output logic                  pop_last,
  output logic [STAT_W-1:0]     pop_status,
  output logic [LEN_W-1:0]      delivered_count,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int OFF_W  = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
  localparam int CMD_W  = SLOT_W + 1 + LEN_W;
  localparam int WR_W   = 2 + SLOT_W + OFF_W + BYTE_W + LEN_W;
  localparam int BST_W  = 1 + SLOT_W;
  localparam int OCNT_W = $clog2(OUT_FIFO_DEPTH + 1);
  localparam int CCNT_W = $clog2(CMD_FIFO_DEPTH + 1);

  logic              cmd_wr;
  logic [CMD_W-1:0]  cmd_wdata;
  logic              cmd_rd;
  logic [CMD_W-1:0]  cmd_rdata;
  logic              cmd_full;
  logic              cmd_empty;
  logic [CCNT_W-1:0] cmd_count;
  logic [WR_W-1:0]   wr_req;
  logic [BST_W-1:0]  back_stat;
  logic              res_wr;
  result_t           res_in;
  result_t           res_head;
  logic [OCNT_W-1:0] res_count;

  // front end
  prb_front #(
    .SLOTS      (SLOTS),
    .SLOT_BYTES (SLOT_BYTES)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .kind            (kind),
    .push_byte       (push_byte),
    .push_last       (push_last),
    .reader_capacity (reader_capacity),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .cmd_wr          (cmd_wr),
    .cmd_data        (cmd_wdata),
    .cmd_full        (cmd_full),
    .cmd_empty       (cmd_empty),
    .wr_req          (wr_req),
    .back_stat       (back_stat)
  );

  // command queue between the two sides
  prb_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_FIFO_DEPTH)
  ) u_cmd_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (cmd_wr),
    .wdata (cmd_wdata),
    .rd    (cmd_rd),
    .rdata (cmd_rdata),
    .empty (cmd_empty),
    .count (cmd_count)
  );

  // command queue full flag
  assign cmd_full = (cmd_count == CCNT_W'(CMD_FIFO_DEPTH));

  // back end
  prb_back #(
    .SLOTS      (SLOTS),
    .SLOT_BYTES (SLOT_BYTES),
    .OUT_DEPTH  (OUT_FIFO_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd_rd    (cmd_rd),
    .cmd_data  (cmd_rdata),
    .wr_req    (wr_req),
    .back_stat (back_stat),
    .res_wr    (res_wr),
    .res       (res_in),
    .res_count (res_count)
  );

  // result queue
  prb_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_FIFO_DEPTH)
  ) u_out_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (res_wr),
    .wdata (res_in),
    .rd    (pop),
    .rdata (res_head),
    .empty (empty),
    .count (res_count)
  );

  // result ports; the back end never writes a full queue
  assign pop_byte        = res_head.data;
  assign pop_last        = res_head.last;
  assign pop_status      = res_head.status;
  assign delivered_count = res_head.count;

endmodule

`default_nettype wire

// ===== hw/rtl/prb_fifo.sv =====
// small register fifo used for the command queue and the result queue
`default_nettype none

module prb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             empty,
  output logic [CNT_W-1:0] count
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             full;
  logic             we;
  logic             re;

  // flags and head beat
  assign empty = (count == '0);
  assign full  = (count == CNT_W'(DEPTH));
  assign we    = wr && !full;
  assign re    = rd && !empty;
  assign rdata = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (we) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (re) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({we, re})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/prb_front.sv =====
// front end: takes beats, runs the write side and slot flags, queues pops
`default_nettype none

module prb_front import prb_pkg::*; #(
  parameter int SLOTS      = DEF_SLOTS,
  parameter int SLOT_BYTES = DEF_SLOT_BYTES,
  localparam int SLOT_W = $clog2(SLOTS),
  localparam int OFF_W  = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1,
  localparam int CMD_W  = SLOT_W + 1 + LEN_W,
  localparam int WR_W   = 2 + SLOT_W + OFF_W + BYTE_W + LEN_W,
  localparam int BST_W  = 1 + SLOT_W
) (
  input  logic                  clk,
  input  logic                  rst,
  // input beats
  input  logic                  push,
  output logic                  full,
  input  logic                  kind,
  input  logic [BYTE_W-1:0]     push_byte,
  input  logic                  push_last,
  input  logic [LEN_W-1:0]      reader_capacity,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // command queue
  output logic                  cmd_wr,
  output logic [CMD_W-1:0]      cmd_data,
  input  logic                  cmd_full,
  input  logic                  cmd_empty,
  // store writes and back end status
  output logic [WR_W-1:0]       wr_req,
  input  logic [BST_W-1:0]      back_stat
);

  localparam int CMP_W = (RING_W > SLOT_W + 1) ? RING_W : SLOT_W + 1;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              hit;
    logic [LEN_W-1:0]  cap;
  } cmd_t;

  typedef struct packed {
    logic              byte_en;
    logic              len_en;
    logic [SLOT_W-1:0] slot;
    logic [OFF_W-1:0]  off;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  len;
  } wr_t;

  typedef struct packed {
    logic              busy;
    logic [SLOT_W-1:0] slot;
  } bstat_t;

  logic [RING_W-1:0] slots_in_use;
  logic [LEN_W-1:0]  packet_limit;
  logic [SLOT_W-1:0] write_slot;
  logic [SLOT_W-1:0] read_slot;
  logic [LEN_W-1:0]  push_fill;
  logic [SLOTS-1:0]  slot_valid;

  logic [CMP_W-1:0]  siu_w;
  logic [CMP_W-1:0]  ring_n;
  logic [LEN_W-1:0]  limit;
  logic              keep;
  logic [LEN_W-1:0]  fill_inc;
  logic              hazard;
  logic              accept;
  logic              acc_push;
  logic              acc_pop;
  logic              hit;
  cmd_t              cmd;
  wr_t               wr;
  bstat_t            bst;

  // next ring position, wrapping at the ring size
  function automatic logic [SLOT_W-1:0] advance(input logic [SLOT_W-1:0] p,
                                                input logic [CMP_W-1:0]  n);
    logic [CMP_W-1:0] q;
    q = CMP_W'(p) + CMP_W'(1);
    return (q >= n) ? '0 : q[SLOT_W-1:0];
  endfunction

  assign bst = bstat_t'(back_stat);

  // clamp ring size and packet limit to their legal ranges
  always_comb begin
    siu_w = CMP_W'(slots_in_use);
    if (siu_w == '0) begin
      ring_n = CMP_W'(1);
    end else if (siu_w > CMP_W'(SLOTS)) begin
      ring_n = CMP_W'(SLOTS);
    end else begin
      ring_n = siu_w;
    end
    if (packet_limit == '0) begin
      limit = LEN_W'(1);
    end else if (packet_limit > LEN_W'(SLOT_BYTES)) begin
      limit = LEN_W'(SLOT_BYTES);
    end else begin
      limit = packet_limit;
    end
  end

  // a push waits while a queued or running pop could still read its slot
  assign hazard   = !cmd_empty || (bst.busy && (bst.slot == write_slot));
  assign full     = (kind == KIND_POP) ? cmd_full : hazard;
  assign accept   = push && !full;
  assign acc_push = accept && (kind == KIND_PUSH);
  assign acc_pop  = accept && (kind == KIND_POP);

  assign keep     = (push_fill < limit);
  assign fill_inc = push_fill + LEN_W'(keep);
  assign hit      = slot_valid[read_slot];

  // pop command toward the back end
  always_comb begin
    cmd.slot = read_slot;
    cmd.hit  = hit;
    cmd.cap  = (reader_capacity > CAP_MAX) ? CAP_MAX : reader_capacity;
  end
  assign cmd_wr   = acc_pop;
  assign cmd_data = cmd;

  // store and length writes
  always_comb begin
    wr.byte_en = acc_push && keep;
    wr.len_en  = acc_push && push_last;
    wr.slot    = write_slot;
    wr.off     = push_fill[OFF_W-1:0];
    wr.data    = push_byte;
    wr.len     = fill_inc;
  end
  assign wr_req    = wr;
  assign cfg_ready = 1'b1;

  // registers, pointers, fill and slot flags
  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= RST_SLOTS_IN_USE;
      packet_limit <= RST_PACKET_LIMIT;
      write_slot   <= '0;
      read_slot    <= '0;
      push_fill    <= '0;
      slot_valid   <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_SLOTS_IN_USE: slots_in_use <= cfg_data[RING_W-1:0];
          REG_PACKET_LIMIT: packet_limit <= cfg_data;
        endcase
      end
      if (acc_push) begin
        if (push_last) begin
          push_fill              <= '0;
          write_slot             <= advance(write_slot, ring_n);
          slot_valid[write_slot] <= 1'b1;
        end else begin
          push_fill <= fill_inc;
        end
      end
      if (acc_pop && hit) begin
        slot_valid[read_slot] <= 1'b0;
        read_slot             <= advance(read_slot, ring_n);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/prb_back.sv =====
// back end: slot store, length table and the pop sequencer
`default_nettype none

module prb_back import prb_pkg::*; #(
  parameter int SLOTS      = DEF_SLOTS,
  parameter int SLOT_BYTES = DEF_SLOT_BYTES,
  parameter int OUT_DEPTH  = OUT_FIFO_DEPTH,
  localparam int SLOT_W = $clog2(SLOTS),
  localparam int OFF_W  = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1,
  localparam int CMD_W  = SLOT_W + 1 + LEN_W,
  localparam int WR_W   = 2 + SLOT_W + OFF_W + BYTE_W + LEN_W,
  localparam int BST_W  = 1 + SLOT_W,
  localparam int OCNT_W = $clog2(OUT_DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst,
  // command queue
  input  logic              cmd_empty,
  output logic              cmd_rd,
  input  logic [CMD_W-1:0]  cmd_data,
  // store writes and status toward the front
  input  logic [WR_W-1:0]   wr_req,
  output logic [BST_W-1:0]  back_stat,
  // result queue
  output logic              res_wr,
  output result_t           res,
  input  logic [OCNT_W-1:0] res_count
);

  localparam int STORE_DEPTH = SLOTS << OFF_W;
  localparam int ADDR_W      = SLOT_W + OFF_W;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              hit;
    logic [LEN_W-1:0]  cap;
  } cmd_t;

  typedef struct packed {
    logic              byte_en;
    logic              len_en;
    logic [SLOT_W-1:0] slot;
    logic [OFF_W-1:0]  off;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  len;
  } wr_t;

  typedef struct packed {
    logic              busy;
    logic [SLOT_W-1:0] slot;
  } bstat_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_LEN,
    B_STREAM
  } bstate_t;

  logic [BYTE_W-1:0] store   [STORE_DEPTH];
  logic [LEN_W-1:0]  len_mem [SLOTS];

  bstate_t           state;
  cmd_t              cur;
  cmd_t              cmd_in;
  wr_t               wr;
  bstat_t            bst;
  logic [LEN_W-1:0]  n;
  logic [LEN_W-1:0]  idx;
  logic [LEN_W-1:0]  idx_inc;
  logic [LEN_W-1:0]  len_rd;
  logic [BYTE_W-1:0] rd_data;
  logic              stage_vld;
  logic              st_last;
  pop_status_t       st_status;
  logic [LEN_W-1:0]  st_count;
  logic              take;
  logic              space;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;

  assign cmd_in = cmd_t'(cmd_data);
  assign wr     = wr_t'(wr_req);

  // room in the result queue counting the beat in flight
  assign space   = ((OCNT_W + 1)'(res_count) + (OCNT_W + 1)'(stage_vld))
                   < (OCNT_W + 1)'(OUT_DEPTH);
  assign take    = (state == B_IDLE) && !cmd_empty;
  assign cmd_rd  = take;
  assign idx_inc = idx + 1'b1;
  assign rd_en   = (state == B_STREAM) && space;
  assign rd_addr = {cur.slot, idx[OFF_W-1:0]};

  // status toward the front end
  always_comb begin
    bst.busy = (state != B_IDLE);
    bst.slot = cur.slot;
  end
  assign back_stat = bst;

  // slot store and length table
  always_ff @(posedge clk) begin
    if (wr.byte_en) begin
      store[{wr.slot, wr.off}] <= wr.data;
    end
    if (wr.len_en) begin
      len_mem[wr.slot] <= wr.len;
    end
    if (take) begin
      len_rd <= len_mem[cmd_in.slot];
    end
    if (rd_en) begin
      rd_data <= store[rd_addr];
    end
  end

  // pop sequencer and result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      stage_vld <= 1'b0;
    end else begin
      stage_vld <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (!cmd_empty) begin
            cur   <= cmd_in;
            state <= B_LEN;
          end
        end
        B_LEN: begin
          if (space) begin
            priority if (!cur.hit) begin
              stage_vld <= 1'b1;
              st_status <= STAT_EMPTY;
              st_last   <= 1'b1;
              st_count  <= '0;
              state     <= B_IDLE;
            end else if (cur.cap == '0) begin
              stage_vld <= 1'b1;
              st_status <= STAT_DISCARD;
              st_last   <= 1'b1;
              st_count  <= '0;
              state     <= B_IDLE;
            end else begin
              n     <= (len_rd < cur.cap) ? len_rd : cur.cap;
              idx   <= '0;
              state <= B_STREAM;
            end
          end
        end
        B_STREAM: begin
          if (space) begin
            stage_vld <= 1'b1;
            st_status <= STAT_DATA;
            st_last   <= (idx_inc == n);
            st_count  <= idx_inc;
            idx       <= idx_inc;
            if (idx_inc == n) begin
              state <= B_IDLE;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // result beat toward the queue
  assign res_wr = stage_vld;
  always_comb begin
    res.data   = (st_status == STAT_DATA) ? rd_data : '0;
    res.last   = st_last;
    res.status = st_status;
    res.count  = st_count;
  end

endmodule

`default_nettype wire

// ===== bench/prb_scoreboard_pkg.sv =====
// scoreboard class that predicts and checks pop result beats of the packet ring buffer
`timescale 1ns / 100ps

package prb_scoreboard_pkg;
  import prb_pkg::*;

  // one input beat as the sender drives it
  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] data;
    logic              last;
    logic [LEN_W-1:0]  cap;
  } in_beat_t;

  class pop_beat_scoreboard;
    // shadow copy of the ring
    logic [BYTE_W-1:0] shadow_bytes [DEF_SLOTS][DEF_SLOT_BYTES];
    int unsigned       shadow_len [DEF_SLOTS];
    int unsigned       wr_ptr;
    int unsigned       rd_ptr;
    int unsigned       fill_count;
    logic [RING_W-1:0] ring_cfg;
    logic [LEN_W-1:0]  limit_cfg;
    result_t           due_beats [$];
    int                errors;

    function new();
      foreach (shadow_len[i]) shadow_len[i] = 0;
      wr_ptr     = 0;
      rd_ptr     = 0;
      fill_count = 0;
      ring_cfg   = RST_SLOTS_IN_USE;
      limit_cfg  = RST_PACKET_LIMIT;
      errors     = 0;
    endfunction

    // effective ring size, clamped to 1..DEF_SLOTS
    function int unsigned ring_slots();
      int unsigned n;
      n = ring_cfg;
      if (n == 0) n = 1;
      if (n > DEF_SLOTS) n = DEF_SLOTS;
      return n;
    endfunction

    // effective packet limit, clamped to 1..DEF_SLOT_BYTES
    function int unsigned byte_limit();
      int unsigned n;
      n = limit_cfg;
      if (n == 0) n = 1;
      if (n > DEF_SLOT_BYTES) n = DEF_SLOT_BYTES;
      return n;
    endfunction

    // pointer advance; anything at or past the ring end wraps to zero
    function int unsigned next_slot(input int unsigned p);
      return (p + 1 >= ring_slots()) ? 0 : p + 1;
    endfunction

    function void set_reg(input logic [CFG_IDX_W-1:0] idx,
                          input logic [CFG_DATA_W-1:0] val);
      if (idx == REG_SLOTS_IN_USE) ring_cfg = val[RING_W-1:0];
      else limit_cfg = val;
    endfunction

    function void add_due(input logic [BYTE_W-1:0] d, input logic l,
                          input pop_status_t s, input logic [LEN_W-1:0] c);
      result_t r;
      r.data   = d;
      r.last   = l;
      r.status = s;
      r.count  = c;
      due_beats.push_back(r);
    endfunction

    // note an accepted input beat and queue the pop beats it causes
    function void take_input_beat(input in_beat_t b);
      int unsigned ws;
      int unsigned rs;
      int unsigned len;
      int unsigned cap;
      int unsigned n;
      ws = wr_ptr % DEF_SLOTS;
      rs = rd_ptr % DEF_SLOTS;
      // push: keep the byte while under the limit, close the slot on last
      if (b.kind == KIND_PUSH) begin
        if (fill_count < byte_limit() && fill_count < DEF_SLOT_BYTES) begin
          shadow_bytes[ws][fill_count] = b.data;
          fill_count++;
        end
        if (b.last) begin
          shadow_len[ws] = fill_count;
          wr_ptr = next_slot(ws);
          fill_count = 0;
        end
        return;
      end
      // pop of an empty slot
      len = shadow_len[rs];
      if (len == 0) begin
        add_due('0, 1'b1, STAT_EMPTY, '0);
        return;
      end
      cap = (b.cap > CAP_MAX) ? CAP_MAX : b.cap;
      shadow_len[rs] = 0;
      rd_ptr = next_slot(rs);
      // zero capacity drops the packet
      if (cap == 0) begin
        add_due('0, 1'b1, STAT_DISCARD, '0);
        return;
      end
      // stream the kept bytes
      n = (len < cap) ? len : cap;
      if (n > DEF_SLOT_BYTES) n = DEF_SLOT_BYTES;
      for (int unsigned i = 0; i < n; i++)
        add_due(shadow_bytes[rs][i], (i + 1 == n), STAT_DATA, LEN_W'(i + 1));
    endfunction

    function int pending();
      return due_beats.size();
    endfunction

    task report(input string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    // compare one accepted pop beat against the oldest expected one
    task check_pop_beat(input result_t got);
      result_t want;
      if (due_beats.size() == 0) begin
        report($sformatf("unexpected beat byte=%0h last=%0b status=%0d count=%0d",
                         got.data, got.last, got.status, got.count));
        return;
      end
      want = due_beats.pop_front();
      if (got.data !== want.data)
        report($sformatf("pop_byte %0h, want %0h", got.data, want.data));
      if (got.last !== want.last)
        report($sformatf("pop_last %0b, want %0b", got.last, want.last));
      if (got.status !== want.status)
        report($sformatf("pop_status %0d, want %0d", got.status, want.status));
      if (got.count !== want.count)
        report($sformatf("delivered_count %0d, want %0d", got.count, want.count));
    endtask
  endclass

endpackage

// ===== bench/packet_ring_buffer_test.sv =====
// testbench top of the packet ring buffer: directed and random beats, scoreboard checks
`timescale 1ns / 100ps

module packet_ring_buffer_test;
  import prb_pkg::*;
  import prb_scoreboard_pkg::*;

  localparam int STALL_LIMIT  = 1000;
  localparam int SETTLE_TICKS = 8;
  localparam int PHASES       = 7;
  localparam int PHASE_BEATS  = 52;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  push = 1'b0;
  logic                  full;
  logic                  kind = KIND_PUSH;
  logic [BYTE_W-1:0]     push_byte = '0;
  logic                  push_last = 1'b0;
  logic [LEN_W-1:0]      reader_capacity = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic [BYTE_W-1:0]     pop_byte;
  logic                  pop_last;
  logic [STAT_W-1:0]     pop_status;
  logic [LEN_W-1:0]      delivered_count;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_SLOTS_IN_USE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pop_beat_scoreboard sb;
  int unsigned        sent = 0;
  bit                 no_gaps = 1'b0;
  int                 stalled_cycles = 0;

  // ring size and packet limit for each random phase
  logic [CFG_DATA_W-1:0] ring_plan [PHASES] = '{7'd4, 7'd1, 7'd0, 7'd31, 7'd2, 7'd17, 7'd16};
  logic [CFG_DATA_W-1:0] limit_plan [PHASES] = '{7'd2, 7'd1, 7'd0, 7'd127, 7'd64, 7'd100, 7'd64};

  packet_ring_buffer uut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .kind(kind), .push_byte(push_byte),
    .push_last(push_last), .reader_capacity(reader_capacity),
    .empty(empty), .pop(pop), .pop_byte(pop_byte), .pop_last(pop_last),
    .pop_status(pop_status), .delivered_count(delivered_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // watchdog: cycles with no beat moving on any channel
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) stalled_cycles <= 0;
    else stalled_cycles <= stalled_cycles + 1;
    if (stalled_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side: random pop stalls, check each accepted beat
  initial begin
    result_t seen;
    while (rst) @(posedge clk);
    forever begin
      @(negedge clk);
      pop <= no_gaps || ($urandom_range(0, 99) >= 10);
      @(posedge clk);
      if (pop && !empty) begin
        seen.data   = pop_byte;
        seen.last   = pop_last;
        seen.status = pop_status_t'(pop_status);
        seen.count  = delivered_count;
        sb.check_pop_beat(seen);
      end
    end
  end

  // drive one input beat after a random gap, wait for acceptance
  task automatic send_beat(input in_beat_t b);
    while (!no_gaps && $urandom_range(0, 99) < 10) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push            <= 1'b1;
    kind            <= b.kind;
    push_byte       <= b.data;
    push_last       <= b.last;
    reader_capacity <= b.cap;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.take_input_beat(b);
    sent++;
  endtask

  // push byte beat; capacity field carries noise
  task automatic send_push(input logic [BYTE_W-1:0] d, input logic l);
    in_beat_t b;
    b.kind = KIND_PUSH;
    b.data = d;
    b.last = l;
    b.cap  = LEN_W'($urandom_range(0, 127));
    send_beat(b);
  endtask

  // pop request beat; byte and last fields carry noise
  task automatic send_pop(input logic [LEN_W-1:0] c);
    in_beat_t b;
    b.kind = KIND_POP;
    b.data = BYTE_W'($urandom_range(0, 255));
    b.last = 1'($urandom_range(0, 1));
    b.cap  = c;
    send_beat(b);
  endtask

  task automatic stop_push();
    @(negedge clk);
    push <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // capacity mix: zero, saturating, full slot, small and mid values
  function automatic logic [LEN_W-1:0] pick_capacity();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return LEN_W'($urandom_range(65, 127));
    if (r < 22) return CAP_MAX;
    if (r < 60) return LEN_W'($urandom_range(1, 8));
    return LEN_W'($urandom_range(1, 63));
  endfunction

  // random phase: mostly whole packets and pops, some open packets and stray bytes
  task automatic run_phase(input int unsigned beats, input bit hold_mid);
    int unsigned first;
    int unsigned len;
    int unsigned r;
    bit          open_end;
    bit          held;
    first = sent;
    held  = 1'b0;
    while (sent - first < beats) begin
      // sender holds off until every expected beat is back
      if (hold_mid && !held && sent - first >= beats / 2) begin
        stop_push();
        drain();
        held = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 50) begin
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 6);
        open_end = ($urandom_range(0, 9) == 0);
        for (int unsigned i = 0; i < len; i++)
          send_push(BYTE_W'($urandom_range(0, 255)), (i + 1 == len) && !open_end);
      end else if (r < 90) begin
        send_pop(pick_capacity());
      end else begin
        send_push(BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty ring, with zero and full capacity
    send_pop('0);
    send_pop(CAP_MAX);
    // one-byte packet, then a two-byte packet read through capacity one
    send_push(8'h00, 1'b1);
    send_push(8'hFF, 1'b0);
    send_push(8'h55, 1'b1);
    send_pop(7'd127);
    send_pop(7'd1);
    // zero capacity drops the packet, the ring then reads empty
    send_push(8'hAA, 1'b1);
    send_pop('0);
    send_pop(CAP_MAX);
    // pop while a packet is only partly pushed
    send_push(8'h01, 1'b0);
    send_pop(CAP_MAX);
    send_push(8'h02, 1'b1);
    send_pop(7'd2);
    // packet left open across the first limit change
    send_push(8'h80, 1'b0);
    send_push(8'h7F, 1'b0);
    send_push(8'h3C, 1'b0);

    // random phases, each under its own ring size and packet limit
    for (int p = 0; p < PHASES; p++) begin
      stop_push();
      drain();
      repeat (SETTLE_TICKS) @(posedge clk);
      write_reg(REG_SLOTS_IN_USE, ring_plan[p]);
      write_reg(REG_PACKET_LIMIT, limit_plan[p]);
      no_gaps = (p == 3);
      run_phase(PHASE_BEATS, p == 4);
    end
    no_gaps = 1'b0;

    // wind down
    stop_push();
    drain();
    repeat (SETTLE_TICKS + 2) @(posedge clk);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
